// ----- rtl/core/srg_pkg.sv -----
// ----------------------------------------------------------------------------
// Subtractive random generator package
// Constants, control types, the modular subtract and the microcode ROM.
// ----------------------------------------------------------------------------
package srg_pkg;

    localparam int VALUE_W = 30;
    localparam int SEED_W  = 28;
    localparam int IDX_W   = 6;
    localparam int PASS_W  = 2;

    localparam logic [VALUE_W-1:0] MODULUS     = 30'd1000000000;
    localparam logic [VALUE_W-1:0] START_CONST = 30'd161803398;
    localparam logic [IDX_W-1:0]   FILL_STRIDE = 6'd21;
    localparam logic [IDX_W-1:0]   TABLE_LEN   = 6'd55;
    localparam logic [IDX_W-1:0]   LAG_START   = 6'd31;
    localparam logic [IDX_W-1:0]   MIX_J_START = 6'd32;
    localparam logic [IDX_W-1:0]   FILL_LAST   = 6'd54;
    localparam logic [PASS_W-1:0]  MIX_LAST    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL_INIT,
        S_FILL,
        S_MIX_RD,
        S_MIX_WR,
        S_BUILD_DONE,
        S_DRAW_RD,
        S_DRAW_WR
    } step_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_FILL_INIT,
        OP_FILL,
        OP_MIX,
        OP_BUILD_DONE,
        OP_DRAW_RD,
        OP_DRAW_WR
    } op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_BUILD,
        COND_FILL_LAST,
        COND_MIX_LAST
    } cond_t;

    typedef enum logic {
        ADDR_DRAW,
        ADDR_MIX
    } rd_sel_t;

    typedef struct packed {
        logic    take_in;
        logic    wait_out;
        cond_t   cond;
        step_t   jump_to;
        step_t   else_to;
        op_t     op;
        rd_sel_t rd_sel;
    } uword_t;

    typedef struct packed {
        step_t   step;
        logic    take_in;
        logic    commit;
        op_t     op;
        rd_sel_t rd_sel;
    } srg_ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic need_build;
        logic fill_last;
        logic mix_last;
        logic out_free;
    } srg_status_t;

    // Difference of two residues, wrapped into [0, MODULUS).
    function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] s;
        if (a >= b)
        begin
            s = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            s = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
        end
        return s[VALUE_W-1:0];
    endfunction

    // Cyclic position step over 1..55.
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p >= TABLE_LEN)
        begin
            r = IDX_W'(1);
        end
        else
        begin
            r = p + IDX_W'(1);
        end
        return r;
    endfunction

    // Control program, one word per step.
    function automatic uword_t srg_ucode(input step_t s);
        uword_t w;
        w = '{take_in: 1'b0, wait_out: 1'b0, cond: COND_ALWAYS, jump_to: S_IDLE,
              else_to: S_IDLE, op: OP_NOP, rd_sel: ADDR_DRAW};
        case (s)
            S_IDLE:
            begin
                w.take_in = 1'b1;
                w.cond    = COND_BUILD;
                w.jump_to = S_FILL_INIT;
                w.else_to = S_DRAW_WR;
                w.op      = OP_DRAW_RD;
            end
            S_FILL_INIT:
            begin
                w.jump_to = S_FILL;
                w.op      = OP_FILL_INIT;
            end
            S_FILL:
            begin
                w.cond    = COND_FILL_LAST;
                w.jump_to = S_MIX_RD;
                w.else_to = S_FILL;
                w.op      = OP_FILL;
            end
            S_MIX_RD:
            begin
                w.jump_to = S_MIX_WR;
                w.rd_sel  = ADDR_MIX;
            end
            S_MIX_WR:
            begin
                w.cond    = COND_MIX_LAST;
                w.jump_to = S_BUILD_DONE;
                w.else_to = S_MIX_RD;
                w.op      = OP_MIX;
            end
            S_BUILD_DONE:
            begin
                w.jump_to = S_DRAW_RD;
                w.op      = OP_BUILD_DONE;
            end
            S_DRAW_RD:
            begin
                w.jump_to = S_DRAW_WR;
                w.op      = OP_DRAW_RD;
            end
            S_DRAW_WR:
            begin
                w.wait_out = 1'b1;
                w.jump_to  = S_IDLE;
                w.op       = OP_DRAW_WR;
            end
            default:
            begin
                w.jump_to = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/srg_req_if.sv -----
// ----------------------------------------------------------------------------
// Draw request channel
// Valid/ready channel that carries one draw request per transaction.
// ----------------------------------------------------------------------------
interface srg_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink (input valid, input reseed, output ready);
endinterface

// ----- rtl/core/srg_res_if.sv -----
// ----------------------------------------------------------------------------
// Drawn value channel
// Valid/ready channel that carries one drawn value per transaction.
// ----------------------------------------------------------------------------
interface srg_res_if
    import srg_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

// ----- rtl/core/subtractive_random_generator.sv -----
// ----------------------------------------------------------------------------
// Subtractive random generator
// Lagged subtractive uniform generator with values in [0, 1e9).
//
// Each transaction on req asks for one draw; each transaction on res returns
// one value. The seed register is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle, which the block itself does
// not enforce, and a write forces a table rebuild before the next draw.
// A steady draw has 2 steps: one reads the two lagged table entries from
// the 55-entry memory, one subtracts, writes back and loads the output
// register that drives res. When a rebuild is needed (after reset, after a
// seed write, or when reseed is set) the draw first runs the build program:
// 1 start step, 54 fill steps, 4 mixing passes of 55 read/write step pairs
// and 1 closing step, then the 2-step draw. Reset clears the control state
// and sets the seed to 1; the table contents are rebuilt before their first
// use. While the receiver stalls, the result waits in the output register
// and the next request is still accepted; that draw then holds before its
// write-back until the output register frees.
// ----------------------------------------------------------------------------
module subtractive_random_generator
    import srg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SEED_W-1:0] cfg_wdata,
    srg_req_if.sink           req,
    srg_res_if.source         res
);

    srg_ctrl_t   ctrl;
    srg_status_t status;

    logic [SEED_W-1:0]  seed_reg;
    logic               ready_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   lag_idx_reg;
    logic [VALUE_W-1:0] cur_reg;
    logic [VALUE_W-1:0] nxt_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   mi_reg;
    logic [IDX_W-1:0]   mj_reg;
    logic [PASS_W-1:0]  pass_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] rd_a_reg;
    logic [VALUE_W-1:0] rd_b_reg;

    logic [VALUE_W-1:0] lag_table [55];

    logic [VALUE_W-1:0] start_val;
    logic [VALUE_W-1:0] diff;
    logic [IDX_W:0]     pos_sum;
    logic [IDX_W-1:0]   pos_next;
    logic [IDX_W-1:0]   rd_adv;
    logic [IDX_W-1:0]   lag_adv;
    logic               draw_go;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [IDX_W-1:0]   ra_a;
    logic [IDX_W-1:0]   ra_b;

    srg_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign req.ready = ctrl.take_in;
    assign res.valid = out_valid_reg;
    assign res.value = value_reg;

    always_comb
    begin
        status.in_fire    = req.valid && ctrl.take_in;
        status.need_build = req.reseed || !ready_reg;
        status.fill_last  = (cnt_reg == FILL_LAST);
        status.mix_last   = (mi_reg == TABLE_LEN) && (pass_reg == MIX_LAST);
        status.out_free   = !out_valid_reg || res.ready;
    end

    always_comb
    begin
        start_val = sub_mod(START_CONST, VALUE_W'(seed_reg));
        diff      = sub_mod(rd_a_reg, rd_b_reg);
        pos_sum   = {1'b0, pos_reg} + {1'b0, FILL_STRIDE};
        if (pos_sum >= {1'b0, TABLE_LEN})
        begin
            pos_next = IDX_W'(pos_sum - {1'b0, TABLE_LEN});
        end
        else
        begin
            pos_next = pos_sum[IDX_W-1:0];
        end
        rd_adv  = advance(rd_idx_reg);
        lag_adv = advance(lag_idx_reg);
        draw_go = ctrl.commit && !(ctrl.take_in && status.need_build);

        case (ctrl.rd_sel)
            ADDR_MIX:
            begin
                ra_a = mi_reg - IDX_W'(1);
                ra_b = mj_reg - IDX_W'(1);
            end
            default:
            begin
                ra_a = rd_adv - IDX_W'(1);
                ra_b = lag_adv - IDX_W'(1);
            end
        endcase

        wr_en   = 1'b0;
        wr_addr = rd_idx_reg - IDX_W'(1);
        wr_data = diff;
        case (ctrl.op)
            OP_FILL_INIT:
            begin
                wr_en   = ctrl.commit;
                wr_addr = TABLE_LEN - IDX_W'(1);
                wr_data = start_val;
            end
            OP_FILL:
            begin
                wr_en   = ctrl.commit;
                wr_addr = pos_reg - IDX_W'(1);
                wr_data = nxt_reg;
            end
            OP_MIX:
            begin
                wr_en   = ctrl.commit;
                wr_addr = mi_reg - IDX_W'(1);
            end
            OP_DRAW_WR:
            begin
                wr_en = ctrl.commit;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lag_table[wr_addr] <= wr_data;
        end
        if (ctrl.op != OP_DRAW_WR)
        begin
            rd_a_reg <= lag_table[ra_a];
            rd_b_reg <= lag_table[ra_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= SEED_W'(1);
            ready_reg   <= 1'b0;
            rd_idx_reg  <= '0;
            lag_idx_reg <= LAG_START;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg  <= cfg_wdata;
                ready_reg <= 1'b0;
            end
            if (ctrl.commit && ctrl.op == OP_BUILD_DONE)
            begin
                ready_reg   <= 1'b1;
                rd_idx_reg  <= '0;
                lag_idx_reg <= LAG_START;
            end
            else if (draw_go && ctrl.op == OP_DRAW_RD)
            begin
                rd_idx_reg  <= rd_adv;
                lag_idx_reg <= lag_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cnt_reg  <= '0;
            mi_reg   <= '0;
            mj_reg   <= '0;
            pass_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            case (ctrl.op)
                OP_FILL_INIT:
                begin
                    pos_reg  <= FILL_STRIDE;
                    cnt_reg  <= IDX_W'(1);
                    mi_reg   <= IDX_W'(1);
                    mj_reg   <= MIX_J_START;
                    pass_reg <= '0;
                end
                OP_FILL:
                begin
                    pos_reg <= pos_next;
                    cnt_reg <= cnt_reg + IDX_W'(1);
                end
                OP_MIX:
                begin
                    mi_reg <= advance(mi_reg);
                    mj_reg <= advance(mj_reg);
                    if (mi_reg == TABLE_LEN)
                    begin
                        pass_reg <= pass_reg + PASS_W'(1);
                    end
                end
                default:
                begin
                    pos_reg <= pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit && ctrl.op == OP_FILL_INIT)
        begin
            cur_reg <= start_val;
            nxt_reg <= VALUE_W'(1);
        end
        else if (ctrl.commit && ctrl.op == OP_FILL)
        begin
            cur_reg <= nxt_reg;
            nxt_reg <= sub_mod(cur_reg, nxt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit && ctrl.op == OP_DRAW_WR)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit && ctrl.op == OP_DRAW_WR)
        begin
            value_reg <= diff;
        end
    end

`ifndef SYNTHESIS
    a_draw_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step == S_DRAW_WR && ctrl.commit) |=> res.valid)
        else $error("draw write-back did not load the output register");

    a_lag_distance: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, lag_idx_reg} == {1'b0, rd_idx_reg} + 7'd31) ||
        ({1'b0, lag_idx_reg} + 7'd24 == {1'b0, rd_idx_reg}))
        else $error("lag index is not 31 positions ahead of read index");

    a_fast_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && !req.reseed && ready_reg) |=> ctrl.step == S_DRAW_WR)
        else $error("draw with a built table did not go to write-back");

    a_fill_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step == S_FILL) |-> (pos_reg != '0 && pos_reg < TABLE_LEN))
        else $error("fill position left the range 1 to 54");

    a_no_output_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |-> !(ctrl.op == OP_DRAW_WR && ctrl.commit))
        else $error("output register overwritten while stalled");
`endif

endmodule

// ----- rtl/core/srg_sequencer.sv -----
// ----------------------------------------------------------------------------
// Subtractive random generator sequencer
// Step counter that walks the control program and applies its jumps.
// ----------------------------------------------------------------------------
module srg_sequencer
    import srg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  srg_status_t status,
    output srg_ctrl_t   ctrl
);

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   hold;
    logic   cond_true;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        uw   = srg_ucode(step_reg);
        hold = (uw.take_in && !status.in_fire) || (uw.wait_out && !status.out_free);
        case (uw.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_BUILD:     cond_true = status.need_build;
            COND_FILL_LAST: cond_true = status.fill_last;
            COND_MIX_LAST:  cond_true = status.mix_last;
            default:        cond_true = 1'b1;
        endcase
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (cond_true)
        begin
            step_next = uw.jump_to;
        end
        else
        begin
            step_next = uw.else_to;
        end
        ctrl.step    = step_reg;
        ctrl.take_in = uw.take_in;
        ctrl.commit  = !hold;
        ctrl.op      = uw.op;
        ctrl.rd_sel  = uw.rd_sel;
    end

endmodule

// ----- bench/tb_subtractive_random_generator.sv -----
// ----------------------------------------------------------------------------
// Subtractive random generator testbench
// Sends draw requests under several seeds, with reseeds mixed in and random
// idling on both channels. A scoreboard keeps its own lag table, works out
// each value when its request is accepted, and compares the values that come
// back in order.
// ----------------------------------------------------------------------------
module tb_subtractive_random_generator
    import srg_pkg::*;
;

    localparam int MIX_OFFSET  = 30;
    localparam int PRESSURE_AT = 150;
    localparam int LONG_HOLD   = 80;
    localparam int CLK_HALF    = 6;

    class draw_scoreboard;
        int unsigned     lag_table [1:55];
        int unsigned     rd_pos;
        int unsigned     lag_pos;
        bit              built;
        bit [SEED_W-1:0] seed;
        bit [VALUE_W-1:0] expected_values [$];
        int              draws;
        int              rebuilds;
        int              mismatches;

        function new();
            seed     = 1;
            built    = 0;
            rd_pos   = 0;
            lag_pos  = LAG_START;
            draws    = 0;
            rebuilds = 0;
            mismatches = 0;
        endfunction

        function int unsigned wrap_sub(input int unsigned a, input int unsigned b);
            int unsigned m;
            m = MODULUS;
            if (a >= b)
            begin
                return a - b;
            end
            return a + m - b;
        endfunction

        function int unsigned next_pos(input int unsigned p);
            return (p == TABLE_LEN) ? 1 : p + 1;
        endfunction

        function void rebuild();
            int unsigned cur;
            int unsigned nxt;
            int unsigned pos;
            int unsigned base;
            int unsigned m;
            base = START_CONST;
            m    = MODULUS;
            if (seed <= base)
            begin
                cur = base - seed;
            end
            else
            begin
                cur = base + m - seed;
            end
            if (cur >= m)
            begin
                cur = cur - m;
            end
            lag_table[TABLE_LEN] = cur;
            nxt = 1;
            for (int i = 1; i < TABLE_LEN; i++)
            begin
                pos = (FILL_STRIDE * i) % TABLE_LEN;
                lag_table[pos] = nxt;
                nxt = wrap_sub(cur, nxt);
                cur = lag_table[pos];
            end
            for (int k = 0; k < 4; k++)
            begin
                for (int i = 1; i <= TABLE_LEN; i++)
                begin
                    lag_table[i] = wrap_sub(lag_table[i],
                                            lag_table[1 + (i + MIX_OFFSET) % TABLE_LEN]);
                end
            end
            rd_pos  = 0;
            lag_pos = LAG_START;
            built   = 1;
            rebuilds++;
        endfunction

        function void load_seed(input bit [SEED_W-1:0] v);
            seed  = v;
            built = 0;
        endfunction

        function void note_draw(input bit reseed);
            int unsigned d;
            if (reseed || !built)
            begin
                rebuild();
            end
            rd_pos  = next_pos(rd_pos);
            lag_pos = next_pos(lag_pos);
            d = wrap_sub(lag_table[rd_pos], lag_table[lag_pos]);
            lag_table[rd_pos] = d;
            expected_values.push_back(d[VALUE_W-1:0]);
        endfunction

        function void check_value(input bit [VALUE_W-1:0] got);
            bit [VALUE_W-1:0] want;
            if (expected_values.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("value %0d arrived with no draw outstanding", got);
                end
                return;
            end
            want = expected_values.pop_front();
            draws++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("draw %0d: expected value %0d, got %0d", draws, want, got);
                end
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SEED_W-1:0] cfg_wdata;

    srg_req_if req ();
    srg_res_if res ();

    subtractive_random_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .res       (res)
    );

    draw_scoreboard sb;
    int             seed_writes;
    int             requests_sent;
    int             values_taken;
    bit             send_eager;
    bit             take_eager;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    task automatic write_seed(input bit [SEED_W-1:0] v);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.load_seed(v);
        seed_writes++;
    endtask

    task automatic send_draw(input bit rs);
        int gap;
        gap = send_eager ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.reseed <= rs;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        sb.note_draw(rs);
        requests_sent++;
        if (requests_sent % 32 == 0)
        begin
            send_eager = ($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic send_random_draws(input int count, input int reseed_pct);
        for (int i = 0; i < count; i++)
        begin
            send_draw($urandom_range(0, 99) < reseed_pct);
        end
        req.valid <= 1'b0;
    endtask

    initial
    begin
        int hold;
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (values_taken == PRESSURE_AT)
            begin
                hold = LONG_HOLD;
            end
            else
            begin
                hold = take_eager ? 0 : $urandom_range(0, 3);
            end
            if (hold != 0)
            begin
                res.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!res.valid);
            sb.check_value(res.value);
            values_taken++;
            if (values_taken % 24 == 0)
            begin
                take_eager = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial
    begin
        #(2 * CLK_HALF * 400000);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        bit [SEED_W-1:0] phase_seed;
        sb = new();
        seed_writes   = 0;
        requests_sent = 0;
        values_taken  = 0;
        send_eager    = 0;
        take_eager    = 0;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        req.valid  <= 1'b0;
        req.reseed <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset seed builds the table on the first draw.
        send_draw(1'b0);
        send_draw(1'b0);
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b0);
        req.valid <= 1'b0;

        write_seed('0);
        send_draw(1'b0);
        send_draw(1'b0);
        send_draw(1'b0);
        req.valid <= 1'b0;

        // A seed equal to the start constant makes the first entry zero.
        write_seed(START_CONST[SEED_W-1:0]);
        send_draw(1'b0);
        send_draw(1'b0);
        req.valid <= 1'b0;

        // Seeds above the start constant wrap the first entry around the modulus.
        write_seed(START_CONST[SEED_W-1:0] + 1'b1);
        send_draw(1'b0);
        send_draw(1'b1);
        send_draw(1'b0);
        req.valid <= 1'b0;

        write_seed('1);
        send_draw(1'b0);
        send_draw(1'b0);
        send_draw(1'b1);
        req.valid <= 1'b0;

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                2: phase_seed = '1;
                4: phase_seed = '0;
                default: phase_seed = SEED_W'($urandom_range(0, (1 << SEED_W) - 1));
            endcase
            write_seed(phase_seed);
            send_random_draws(106, 3);
        end

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Covered %0d draws with %0d table builds across %0d seed settings.",
                 sb.draws, sb.rebuilds, seed_writes + 1);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
